[rtl/core/clcs_pkg.sv]
// ----------------------------------------------------------------------------
// clcs_pkg
// Shared types, constants and address helpers for the character LCD cursor
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcs_pkg;

  localparam int unsigned ADDR_W        = 7;
  localparam int unsigned COLUMNS       = 16;
  localparam int unsigned LINE_TWO_BASE = 65;
  localparam int unsigned LINE_TWO_END  = LINE_TWO_BASE + COLUMNS - 1;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t ADDR_HOME = addr_t'(1);
  localparam addr_t ADDR_MAX  = addr_t'(127);

  localparam logic [7:0] DISPLAY_CLEAR_INSTR = 8'h01;
  localparam logic [7:0] LCD_SPACE           = 8'h20;
  localparam logic [7:0] BAD_ADDR_BYTE       = 8'hFF;

  typedef enum logic [3:0] {
    CMD_WRITE_CHAR = 4'd0,
    CMD_CLEAR      = 4'd1,
    CMD_CLEAR_EOL  = 4'd2,
    CMD_UP         = 4'd3,
    CMD_DOWN       = 4'd4,
    CMD_LEFT       = 4'd5,
    CMD_RIGHT      = 4'd6,
    CMD_SET_POS    = 4'd7,
    CMD_GET_POS    = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPACE,
    ST_CURSOR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch the incoming beat
    logic exec;         // run the command, emit its first result
    logic space_start;  // load the space counter from the cursor
    logic space_emit;   // emit one space
    logic cursor_emit;  // emit the closing DDRAM address write
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic is_write_char;
    logic eol_run;
    logic space_done;
  } stat_t;

  function automatic logic on_line_one(addr_t a);
    return (a >= addr_t'(1)) && (a <= addr_t'(COLUMNS));
  endfunction

  function automatic logic on_line_two(addr_t a);
    return (a >= addr_t'(LINE_TWO_BASE)) && (a <= addr_t'(LINE_TWO_END));
  endfunction

  function automatic logic [7:0] ddram_byte(addr_t a);
    addr_t m;
    m = a - addr_t'(1);
    if (on_line_one(a) || on_line_two(a)) begin
      return {1'b1, m};
    end
    return BAD_ADDR_BYTE;
  endfunction

  function automatic logic [1:0] row_of(addr_t a);
    if (on_line_one(a)) begin
      return 2'd1;
    end
    if (on_line_two(a)) begin
      return 2'd2;
    end
    return 2'd0;
  endfunction

  function automatic logic [4:0] col_of(addr_t a);
    addr_t c;
    c = a - addr_t'(LINE_TWO_BASE) + addr_t'(1);
    if (on_line_one(a)) begin
      return a[4:0];
    end
    if (on_line_two(a)) begin
      return c[4:0];
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

[rtl/core/clcs_ctrl.sv]
// ----------------------------------------------------------------------------
// clcs_ctrl
// Command sequencer: walks each command through decode and, where the command
// needs them, the space run and the closing cursor write.
// ----------------------------------------------------------------------------
`default_nettype none

module clcs_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  clcs_pkg::stat_t   stat_i,
  output clcs_pkg::ctrl_t   ctrl_o
);

  import clcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.out_free) begin
          if (stat_i.eol_run) begin
            ctrl_o.space_start = 1'b1;
            state_d            = ST_SPACE;
          end else begin
            ctrl_o.exec = 1'b1;
            state_d     = stat_i.is_write_char ? ST_CURSOR : ST_IDLE;
          end
        end
      end
      ST_SPACE: begin
        if (stat_i.out_free) begin
          ctrl_o.space_emit = 1'b1;
          if (stat_i.space_done) begin
            state_d = ST_CURSOR;
          end
        end
      end
      ST_CURSOR: begin
        if (stat_i.out_free) begin
          ctrl_o.cursor_emit = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/clcs_datapath.sv]
// ----------------------------------------------------------------------------
// clcs_datapath
// Cursor and error state, command latch, space counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcs_datapath (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  clcs_pkg::ctrl_t  ctrl_i,
  output clcs_pkg::stat_t  stat_o,
  input  wire  [3:0]       command_i,
  input  wire  [7:0]       char_code_i,
  input  wire  [1:0]       row_request_i,
  input  wire  [4:0]       column_request_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic             write_valid_o,
  output logic             reg_select_o,
  output logic [7:0]       lcd_byte_o,
  output logic             ok_o,
  output logic [1:0]       cursor_row_o,
  output logic [4:0]       cursor_column_o,
  output logic             last_o
);

  import clcs_pkg::*;

  // command latch
  logic [3:0] cmd_q;
  logic [7:0] char_q;
  logic [1:0] row_q;
  logic [4:0] col_q;

  // architectural state
  addr_t addr_q, addr_d;
  logic  err_q, err_d;
  addr_t cnt_q;

  // output register
  logic       vld_q;
  logic       wr_q, rs_q, ok_q, last_q;
  logic [7:0] byte_q;
  logic [1:0] crow_q;
  logic [4:0] ccol_q;

  // exec results
  logic       x_wr, x_rs, x_ok, x_last, x_cur;
  logic [7:0] x_byte;
  addr_t      inc_a, dec_a, lim, col_a;
  logic       addr_ok, emit, out_free;

  assign addr_ok  = on_line_one(addr_q) || on_line_two(addr_q);
  assign inc_a    = (addr_q == ADDR_MAX) ? ADDR_MAX : addr_q + addr_t'(1);
  assign dec_a    = (addr_q == '0) ? '0 : addr_q - addr_t'(1);
  assign lim      = on_line_one(addr_q) ? addr_t'(COLUMNS) : addr_t'(LINE_TWO_END);
  assign col_a    = addr_t'(col_q);
  assign out_free = !vld_q || out_ready_i;
  assign emit     = ctrl_i.exec || ctrl_i.space_emit || ctrl_i.cursor_emit;

  assign stat_o.out_free      = out_free;
  assign stat_o.is_write_char = (cmd_q == CMD_WRITE_CHAR);
  assign stat_o.eol_run       = (cmd_q == CMD_CLEAR_EOL) && addr_ok && !err_q;
  assign stat_o.space_done    = (cnt_q == lim);

  always_comb begin
    addr_d = addr_q;
    err_d  = err_q;
    x_wr   = 1'b0;
    x_rs   = 1'b0;
    x_byte = '0;
    x_ok   = 1'b0;
    x_last = 1'b1;
    x_cur  = 1'b0;
    unique case (cmd_q)
      CMD_WRITE_CHAR: begin
        x_wr   = 1'b1;
        x_rs   = 1'b1;
        x_byte = char_q;
        x_ok   = 1'b1;
        x_last = 1'b0;
        addr_d = inc_a;
        if (inc_a == addr_t'(COLUMNS + 1)) begin
          addr_d = addr_t'(LINE_TWO_BASE);
        end else if (inc_a == addr_t'(LINE_TWO_END + 1)) begin
          addr_d = ADDR_HOME;
        end
      end
      CMD_CLEAR: begin
        x_wr   = 1'b1;
        x_byte = DISPLAY_CLEAR_INSTR;
        x_ok   = 1'b1;
        addr_d = ADDR_HOME;
      end
      CMD_CLEAR_EOL: begin
        // only reached when the run is refused; bad cursor makes it sticky
        if (!addr_ok) begin
          err_d = 1'b1;
        end
      end
      CMD_UP: begin
        if (on_line_two(addr_q)) begin
          addr_d = addr_q - addr_t'(LINE_TWO_BASE - 1);
          x_cur  = 1'b1;
          x_ok   = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (on_line_one(addr_q)) begin
          addr_d = addr_q + addr_t'(LINE_TWO_BASE - 1);
          x_cur  = 1'b1;
          x_ok   = 1'b1;
        end
      end
      CMD_LEFT: begin
        x_cur = 1'b1;
        x_ok  = 1'b1;
        if (addr_q == ADDR_HOME) begin
          x_ok = 1'b0;
        end else if (addr_q == addr_t'(LINE_TWO_BASE)) begin
          addr_d = addr_t'(COLUMNS);
        end else begin
          addr_d = dec_a;
        end
      end
      CMD_RIGHT: begin
        x_cur  = 1'b1;
        x_ok   = 1'b1;
        addr_d = inc_a;
        if (inc_a == addr_t'(COLUMNS + 1)) begin
          addr_d = addr_t'(LINE_TWO_BASE);
        end else if (inc_a == addr_t'(LINE_TWO_END + 1)) begin
          addr_d = addr_t'(LINE_TWO_END);
          x_ok   = 1'b0;
        end
      end
      CMD_SET_POS: begin
        x_cur = 1'b1;
        x_ok  = 1'b1;
        if (row_q == 2'd1) begin
          addr_d = col_a;
        end else if (row_q == 2'd2) begin
          addr_d = col_a + addr_t'(LINE_TWO_BASE - 1);
        end else begin
          x_ok = 1'b0;
        end
        if (col_q == '0 || col_a > addr_t'(COLUMNS)) begin
          x_ok = 1'b0;
        end
      end
      CMD_GET_POS: begin
        x_ok = addr_ok;
      end
      default: begin
        x_ok = 1'b0;
      end
    endcase
    if (x_cur) begin
      x_wr   = 1'b1;
      x_byte = ddram_byte(addr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= command_i;
      char_q <= char_code_i;
      row_q  <= row_request_i;
      col_q  <= column_request_i;
    end
    if (ctrl_i.space_start) begin
      cnt_q <= addr_q;
    end else if (ctrl_i.space_emit) begin
      cnt_q <= cnt_q + addr_t'(1);
    end
    if (ctrl_i.exec) begin
      wr_q   <= x_wr;
      rs_q   <= x_rs;
      byte_q <= x_byte;
      ok_q   <= x_ok;
      crow_q <= row_of(addr_d);
      ccol_q <= col_of(addr_d);
      last_q <= x_last;
    end else if (ctrl_i.space_emit || ctrl_i.cursor_emit) begin
      wr_q   <= 1'b1;
      rs_q   <= ctrl_i.space_emit;
      byte_q <= ctrl_i.space_emit ? LCD_SPACE : ddram_byte(addr_q);
      ok_q   <= 1'b1;
      crow_q <= row_of(addr_q);
      ccol_q <= col_of(addr_q);
      last_q <= ctrl_i.cursor_emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_HOME;
      err_q  <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        addr_q <= addr_d;
        err_q  <= err_d;
      end
      if (out_free) begin
        vld_q <= emit;
      end
    end
  end

  assign out_valid_o     = vld_q;
  assign write_valid_o   = wr_q;
  assign reg_select_o    = rs_q;
  assign lcd_byte_o      = byte_q;
  assign ok_o            = ok_q;
  assign cursor_row_o    = crow_q;
  assign cursor_column_o = ccol_q;
  assign last_o          = last_q;

  // a beat without a bus write carries a zero byte on the instruction side
  a_idle_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !wr_q |-> byte_q == '0 && !rs_q)
    else $error("no-write beat with nonzero byte or data select");

  // data writes only come from write char and clear to end of line
  a_data_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && rs_q |-> ok_q && wr_q)
    else $error("data write beat without ok");

  // the space run never leaves the cursor's line
  a_space_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.space_emit |-> cnt_q <= lim && addr_ok)
    else $error("space run past end of line");

  // error flag is sticky until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(err_q))
    else $error("error flag cleared without reset");

endmodule

`default_nettype wire

[rtl/core/char_lcd_cursor_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer_core
// 2x16 character LCD front end: commands in, LCD bus writes out.
// ----------------------------------------------------------------------------
// A command beat is taken whenever the sequencer is idle, even while the last
// result beat of the previous command still waits in the output register.
// Each command then produces its result beats one per cycle as the master
// side drains them: one beat for clear, moves, set/get position and refused
// commands (a no-write beat when nothing goes to the LCD), two beats for
// write char (data byte, then DDRAM address), and for clear to end of line
// one space per column up to the end of the cursor's line plus the closing
// DDRAM address write. A command occupies the block until its last beat
// is loaded into the output register, so clear to end of line holds it
// longest: its space run goes one beat per cycle through the single output
// register while the master side keeps that register free. The cursor address
// resets to line one, column one; the error flag set by clear to end of line
// on a bad cursor stays set until reset and refuses every later clear to end
// of line. tlast marks the final beat of each command; ok, row and column
// are the same on all beats of a command and show the cursor after the
// command.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_cursor_sequencer_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [7:0] char_code, [9:8] row_request,
                                      // [14:10] column_request, [15] zero
  input  wire  [3:0]  s_axis_tuser,   // [3:0] command
  // LCD write stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] write_valid, [8:1] lcd_byte, [9] ok,
                                      // [11:10] cursor_row,
                                      // [16:12] cursor_column, [23:17] zero
  output logic        m_axis_tuser,   // [0] reg_select
  output logic        m_axis_tlast
);

  import clcs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic       write_valid;
  logic [7:0] lcd_byte;
  logic       ok;
  logic [1:0] cursor_row;
  logic [4:0] cursor_column;

  clcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  clcs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .command_i        (s_axis_tuser),
    .char_code_i      (s_axis_tdata[7:0]),
    .row_request_i    (s_axis_tdata[9:8]),
    .column_request_i (s_axis_tdata[14:10]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .write_valid_o    (write_valid),
    .reg_select_o     (m_axis_tuser),
    .lcd_byte_o       (lcd_byte),
    .ok_o             (ok),
    .cursor_row_o     (cursor_row),
    .cursor_column_o  (cursor_column),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, cursor_column, cursor_row, ok, lcd_byte, write_valid};

endmodule

`default_nettype wire

[tb/sv/tb_char_lcd_cursor_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_cursor_sequencer_core
// Self-checking bench for the 2x16 LCD cursor sequencer. Commands go in on the
// slave stream with random gaps. A cursor and error-flag predictor builds the
// expected LCD write beats for every accepted command. A checker compares each
// master-side beat, field by field, against the oldest expected beat while the
// receiver stalls at random and, once, for a long stretch.
// ----------------------------------------------------------------------------
module tb_char_lcd_cursor_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import clcs_pkg::*;

  localparam int          CLK_PERIOD    = 2;
  localparam int          RESET_CYCLES  = 11;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam logic [3:0]  FIRST_SPARE_CMD = 4'd9;
  localparam logic [3:0]  LAST_SPARE_CMD  = 4'd15;

  // one LCD write beat as the master side presents it
  typedef struct packed {
    logic       wr;
    logic       rs;
    logic [7:0] data;
    logic       ok;
    logic [1:0] row;
    logic [4:0] col;
    logic       last;
  } lcd_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // predictor state
  addr_t       cursor_addr = ADDR_HOME;
  logic        eol_locked = 1'b0;
  lcd_beat_t   beats_due[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        hold_req = 1'b0;
  logic        quiet = 1'b0;

  char_lcd_cursor_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Cursor predictor
  // --------------------------------------------------------------------------
  function automatic logic in_line_one(addr_t a);
    return (a >= 1) && (a <= COLUMNS);
  endfunction

  function automatic logic in_line_two(addr_t a);
    return (a >= LINE_TWO_BASE) && (a <= LINE_TWO_END);
  endfunction

  function automatic addr_t clamp_addr(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(ADDR_MAX)) begin
      return ADDR_MAX;
    end
    return addr_t'(v);
  endfunction

  // DDRAM set-address instruction, 0xFF when the cursor is off both lines
  function automatic logic [7:0] ddram_instr(addr_t a);
    addr_t off;
    off = a - addr_t'(1);
    if (in_line_one(a) || in_line_two(a)) begin
      return {1'b1, off};
    end
    return BAD_ADDR_BYTE;
  endfunction

  function automatic lcd_beat_t bus_write(logic rs, logic [7:0] d);
    lcd_beat_t b;
    b = '0;
    b.wr = 1'b1;
    b.rs = rs;
    b.data = d;
    return b;
  endfunction

  // Advance the cursor model by one command and queue the beats it causes.
  function automatic void predict_lcd_writes(logic [3:0] cmd, logic [7:0] ch,
                                             logic [1:0] row, logic [4:0] col);
    lcd_beat_t w[$];
    lcd_beat_t b;
    logic      ok;
    int        lim;
    logic [1:0] crow;
    logic [4:0] ccol;
    ok = 1'b0;
    lim = 0;
    case (cmd)
      CMD_WRITE_CHAR: begin
        w.push_back(bus_write(1'b1, ch));
        cursor_addr = clamp_addr(int'(cursor_addr) + 1);
        if (cursor_addr == COLUMNS + 1) cursor_addr = addr_t'(LINE_TWO_BASE);
        if (cursor_addr == LINE_TWO_END + 1) cursor_addr = ADDR_HOME;
        w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
        ok = 1'b1;
      end
      CMD_CLEAR: begin
        w.push_back(bus_write(1'b0, DISPLAY_CLEAR_INSTR));
        cursor_addr = ADDR_HOME;
        ok = 1'b1;
      end
      CMD_CLEAR_EOL: begin
        // off both lines: the error flag latches until reset
        if (in_line_one(cursor_addr)) lim = COLUMNS;
        else if (in_line_two(cursor_addr)) lim = LINE_TWO_END;
        else eol_locked = 1'b1;
        if (!eol_locked) begin
          for (int a = int'(cursor_addr); a <= lim; a++) begin
            w.push_back(bus_write(1'b1, LCD_SPACE));
          end
          w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
          ok = 1'b1;
        end
      end
      CMD_UP: begin
        if (in_line_two(cursor_addr)) begin
          cursor_addr = cursor_addr - addr_t'(LINE_TWO_BASE - 1);
          w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
          ok = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (in_line_one(cursor_addr)) begin
          cursor_addr = clamp_addr(int'(cursor_addr) + LINE_TWO_BASE - 1);
          w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
          ok = 1'b1;
        end
      end
      CMD_LEFT: begin
        ok = 1'b1;
        if (cursor_addr == ADDR_HOME) ok = 1'b0;
        else if (cursor_addr == LINE_TWO_BASE) cursor_addr = addr_t'(COLUMNS);
        else cursor_addr = clamp_addr(int'(cursor_addr) - 1);
        w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
      end
      CMD_RIGHT: begin
        ok = 1'b1;
        cursor_addr = clamp_addr(int'(cursor_addr) + 1);
        if (cursor_addr == COLUMNS + 1) cursor_addr = addr_t'(LINE_TWO_BASE);
        if (cursor_addr == LINE_TWO_END + 1) begin
          cursor_addr = addr_t'(LINE_TWO_END);
          ok = 1'b0;
        end
        w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
      end
      CMD_SET_POS: begin
        ok = 1'b1;
        if (row == 2'd1) cursor_addr = clamp_addr(int'(col));
        else if (row == 2'd2) cursor_addr = clamp_addr(int'(col) + LINE_TWO_BASE - 1);
        else ok = 1'b0;
        if (col < 1 || col > COLUMNS) ok = 1'b0;
        w.push_back(bus_write(1'b0, ddram_instr(cursor_addr)));
      end
      CMD_GET_POS: begin
        ok = in_line_one(cursor_addr) || in_line_two(cursor_addr);
      end
      default: begin
      end
    endcase

    // commands without a bus write still return one status beat
    if (w.size() == 0) w.push_back('0);

    crow = 2'd0;
    ccol = 5'd0;
    if (in_line_one(cursor_addr)) begin
      crow = 2'd1;
      ccol = cursor_addr[4:0];
    end else if (in_line_two(cursor_addr)) begin
      crow = 2'd2;
      ccol = 5'(cursor_addr - addr_t'(LINE_TWO_BASE) + addr_t'(1));
    end
    for (int k = 0; k < w.size(); k++) begin
      b = w[k];
      b.ok = ok;
      b.row = crow;
      b.col = ccol;
      b.last = (k == w.size() - 1);
      beats_due.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: one beat, optional leading gap, predict on acceptance
  // --------------------------------------------------------------------------
  task automatic send_cmd(logic [3:0] cmd, logic [7:0] ch = 8'h00,
                          logic [1:0] row = 2'd0, logic [4:0] col = 5'd0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, col, row, ch};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_lcd_writes(cmd, ch, row, col);
    @(negedge clk_i);
  endtask

  task automatic send_random_cmds(int count, bit allow_lock);
    logic [3:0] cmd;
    logic [7:0] ch;
    logic [1:0] row;
    logic [4:0] col;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom_range(0, 255));
      row  = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                         : 2'($urandom_range(1, 2));
      col  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(1, COLUMNS));
      if (pick < 12)      cmd = CMD_WRITE_CHAR;
      else if (pick < 17) cmd = CMD_CLEAR;
      else if (pick < 30) cmd = CMD_CLEAR_EOL;
      else if (pick < 40) cmd = CMD_UP;
      else if (pick < 50) cmd = CMD_DOWN;
      else if (pick < 60) cmd = CMD_LEFT;
      else if (pick < 70) cmd = CMD_RIGHT;
      else if (pick < 88) cmd = CMD_SET_POS;
      else if (pick < 94) cmd = CMD_GET_POS;
      else                cmd = 4'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
      // keep the error flag clear until the space runs have been exercised
      if (cmd == CMD_CLEAR_EOL && !allow_lock &&
          !(in_line_one(cursor_addr) || in_line_two(cursor_addr))) begin
        cmd = CMD_SET_POS;
        row = 2'd1;
        col = 5'($urandom_range(1, COLUMNS));
      end
      send_cmd(cmd, ch, row, col);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_basic_commands();
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_GET_POS);
    send_cmd(CMD_LEFT);                  // refused at home
    send_cmd(CMD_UP);                    // refused on line one
    send_cmd(CMD_CLEAR_EOL);             // full line of spaces
    send_cmd(CMD_WRITE_CHAR, 8'h00);
    send_cmd(CMD_WRITE_CHAR, 8'hFF);
    send_cmd(FIRST_SPARE_CMD, 8'hFF, 2'd3, 5'd31);
    send_cmd(LAST_SPARE_CMD);
  endtask

  task automatic test_line_wrap();
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd16);
    send_cmd(CMD_WRITE_CHAR, 8'h41);     // end of line one wraps to line two
    send_cmd(CMD_SET_POS, 8'h00, 2'd2, 5'd16);
    send_cmd(CMD_RIGHT);                 // refused at end of line two
    send_cmd(CMD_CLEAR_EOL);             // single space
    send_cmd(CMD_WRITE_CHAR, 8'h5A);     // end of line two wraps home
    send_cmd(CMD_DOWN);
    send_cmd(CMD_LEFT);                  // start of line two back to line one
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_UP);
  endtask

  task automatic test_bad_positions();
    send_cmd(CMD_SET_POS, 8'h00, 2'd0, 5'd5);   // bad row, cursor kept
    send_cmd(CMD_SET_POS, 8'h00, 2'd3, 5'd31);
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd0);   // address 0
    send_cmd(CMD_LEFT);                         // saturates at 0
    send_cmd(CMD_GET_POS);
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd17);
    send_cmd(CMD_SET_POS, 8'h00, 2'd2, 5'd0);
    send_cmd(CMD_LEFT);
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_CLEAR_EOL);
    for (int i = 0; i < 8; i++) begin
      send_cmd(CMD_WRITE_CHAR, 8'($urandom_range(0, 255)));
    end
    send_cmd(CMD_CLEAR_EOL);
  endtask

  task automatic test_sticky_error();
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd0);
    send_cmd(CMD_CLEAR_EOL);             // invalid cursor latches the error
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd1);
    send_cmd(CMD_CLEAR_EOL);             // still refused
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_CLEAR_EOL);
    send_cmd(CMD_GET_POS);
  endtask

  // walks the address off the lines to both saturation points
  task automatic test_address_walk();
    logic [3:0] dir;
    send_cmd(CMD_SET_POS, 8'h00, 2'd2, 5'd31);
    repeat (34) send_cmd(CMD_RIGHT);
    send_cmd(CMD_WRITE_CHAR, 8'h7E);     // stays at 127
    repeat (3) send_cmd(CMD_LEFT);
    send_cmd(CMD_SET_POS, 8'h00, 2'd1, 5'd0);
    send_cmd(CMD_LEFT);
    send_cmd(CMD_WRITE_CHAR, 8'h30);
    repeat (3) begin
      case ($urandom_range(0, 4))
        0: dir = CMD_LEFT;
        1: dir = CMD_RIGHT;
        2: dir = CMD_UP;
        3: dir = CMD_DOWN;
        default: dir = CMD_WRITE_CHAR;
      endcase
      repeat ($urandom_range(3, 20)) send_cmd(dir, 8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Beat checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    lcd_beat_t got;
    lcd_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.wr   = m_axis_tdata[0];
      got.rs   = m_axis_tuser;
      got.data = m_axis_tdata[8:1];
      got.ok   = m_axis_tdata[9];
      got.row  = m_axis_tdata[11:10];
      got.col  = m_axis_tdata[16:12];
      got.last = m_axis_tlast;
      if (beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
      end else begin
        want = beats_due.pop_front();
        check_field("write_valid", want.wr, got.wr);
        check_field("reg_select", want.rs, got.rs);
        check_field("lcd_byte", want.data, got.data);
        check_field("ok", want.ok, got.ok);
        check_field("cursor_row", want.row, got.row);
        check_field("cursor_column", want.col, got.col);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_commands();
    test_line_wrap();
    test_bad_positions();
    send_random_cmds(180, 1'b0);
    test_output_backpressure();
    test_sticky_error();
    test_address_walk();
    send_random_cmds(120, 1'b1);
    quiet = 1'b1;                        // closing stretch at full rate
    send_random_cmds(60, 1'b1);
    s_axis_tvalid = 1'b0;

    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (beats_due.size() != 0) begin
      $display("%0t: %0d beats never arrived, next expected %p",
               $time, beats_due.size(), beats_due[0]);
    end
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
